/* hw/rtl/tss_pkg.sv */
// Package for the toolpath segment shader: widths, register indexes,
// opacity constants and the divide-by-255 helper.
// Depends on nothing; compiled first.
`default_nettype none

package tss_pkg;

    localparam int DEPTH_FRAC_BITS = 10;
    localparam int DEPTH_W         = DEPTH_FRAC_BITS + 1;
    localparam int DSQ_W           = 2 * DEPTH_FRAC_BITS + 1;

    localparam int HEIGHT_W = 24;
    localparam int SCALE_W  = 32;
    localparam int COLOR_W  = 24;
    localparam int GAIN_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIFF_W = HEIGHT_W + 2;
    localparam int PROD_W = (DIFF_W - 1) + SCALE_W;
    localparam int FRAC_SHIFT = 17;

    localparam logic [7:0] OPA_40    = 8'd102;
    localparam logic [7:0] OPA_60    = 8'd153;
    localparam logic [7:0] OPA_90    = 8'd229;
    localparam logic [7:0] OPA_COVER = 8'd255;

    localparam logic [GAIN_W-1:0] GAIN_MIN = GAIN_W'(128);
    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(512);

    localparam logic [16:0] FRAC_ONE = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEIGHT_OFFSET   = 3'd0,
        REG_HEIGHT_SCALE    = 3'd1,
        REG_HIGHLIGHT_COLOR = 3'd2,
        REG_EXCLUDED_COLOR  = 3'd3,
        REG_BRIGHTNESS      = 3'd4,
        REG_GLOBAL_OPACITY  = 3'd5,
        REG_SHOW_EXTRUSION  = 3'd6,
        REG_SHOW_TRAVEL     = 3'd7
    } cfg_index_t;

    // Per-segment style flags that travel with the data down the pipeline.
    typedef struct packed {
        logic       visible;
        logic [1:0] stroke_width;
        logic [7:0] base_alpha;
        logic       highlighted;
        logic       excluded;
    } seg_ctl_t;

    // Exact floor(x / 255) for x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tss_if.sv */
// Handshake interfaces of the toolpath segment shader: segment input,
// style output and configuration write channel.
// Depends on tss_pkg for field widths.
`default_nettype none

interface tss_seg_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tss_pkg::HEIGHT_W-1:0]  start_height;
    logic signed [tss_pkg::HEIGHT_W-1:0]  end_height;
    logic        [tss_pkg::DEPTH_W-1:0]   depth_fraction;
    logic                                 extrusion;
    logic                                 highlighted;
    logic                                 excluded;

    modport source (output valid, start_height, end_height, depth_fraction,
                    extrusion, highlighted, excluded, input ready);
    modport sink   (input valid, start_height, end_height, depth_fraction,
                    extrusion, highlighted, excluded, output ready);
endinterface

interface tss_style_if;
    logic       valid;
    logic       ready;
    logic       visible;
    logic [1:0] stroke_width;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity;

    modport source (output valid, visible, stroke_width, red, green, blue, opacity,
                    input ready);
    modport sink   (input valid, visible, stroke_width, red, green, blue, opacity,
                    output ready);
endinterface

interface tss_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tss_pkg::CFG_IDX_W-1:0]     index;
    logic [tss_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/toolpath_segment_shader.sv */
// Top level of the toolpath segment shader: configuration registers and a
// six-stage pipeline from segment item to style item.
// Depends on tss_pkg and the interfaces in tss_if.sv.
`default_nettype none

// Usage
// The block takes one toolpath segment item on the segment channel and
// returns one style item on the style channel for each, in order.
// Configuration registers are written through the cfg channel, whose ready
// is always high; write them only while no segment item is in flight.
// Each style item is driven from the output register. Throughput is one
// item per cycle: a new segment item is taken in every cycle in which the
// output register is empty or the style receiver takes the item it holds.
// The six stages are: height sum and depth square, height-scale multiply
// and depth factor, rainbow colour and base-opacity multiply, brightness
// gain and first divide by 255, global-opacity multiply, final divide.
// The whole pipeline advances together when the output register is empty
// or its item is taken; when the receiver stalls, every stage holds, so
// nothing is lost or repeated, and segment.ready goes low.
// Reset clears all valid bits and loads the register reset values; no
// clearing pass is needed.
module toolpath_segment_shader (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tss_seg_if.sink     segment,
    tss_style_if.source style,
    tss_cfg_if.sink     cfg
);
    import tss_pkg::*;

    // Configuration registers.
    logic signed [HEIGHT_W-1:0] height_offset_reg;
    logic [SCALE_W-1:0]         height_scale_reg;
    logic [COLOR_W-1:0]         highlight_color_reg;
    logic [COLOR_W-1:0]         excluded_color_reg;
    logic [GAIN_W-1:0]          brightness_reg;
    logic [7:0]                 global_opacity_reg;
    logic                       show_extrusion_reg;
    logic                       show_travel_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_offset_reg   <= '0;
            height_scale_reg    <= SCALE_W'(65536);
            highlight_color_reg <= '0;
            excluded_color_reg  <= '0;
            brightness_reg      <= GAIN_W'(256);
            global_opacity_reg  <= 8'd229;
            show_extrusion_reg  <= 1'b1;
            show_travel_reg     <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_HEIGHT_OFFSET:   height_offset_reg   <= cfg.data[HEIGHT_W-1:0];
                REG_HEIGHT_SCALE:    height_scale_reg    <= cfg.data[SCALE_W-1:0];
                REG_HIGHLIGHT_COLOR: highlight_color_reg <= cfg.data[COLOR_W-1:0];
                REG_EXCLUDED_COLOR:  excluded_color_reg  <= cfg.data[COLOR_W-1:0];
                REG_BRIGHTNESS:      brightness_reg      <= cfg.data[GAIN_W-1:0];
                REG_GLOBAL_OPACITY:  global_opacity_reg  <= cfg.data[7:0];
                REG_SHOW_EXTRUSION:  show_extrusion_reg  <= cfg.data[0];
                REG_SHOW_TRAVEL:     show_travel_reg     <= cfg.data[0];
                default:             height_offset_reg   <= height_offset_reg;
            endcase
        end
    end

    // All stages move together; the output register frees the last slot.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic advance;

    assign advance       = !v6_reg || style.ready;
    assign segment.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= segment.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Stage 1: doubled midpoint height above the offset, squared depth,
    // and the style flags. Excluded wins over highlighted, which wins over
    // the segment kind.
    logic signed [DIFF_W-1:0] diff_next, diff_reg;
    logic [DEPTH_W-1:0]       depth_clamped;
    logic [DSQ_W-1:0]         dsq_next, dsq_reg;
    seg_ctl_t                 ctl_next, ctl1_reg;

    always_comb
    begin
        diff_next = DIFF_W'(segment.start_height) + DIFF_W'(segment.end_height)
                  - (DIFF_W'(height_offset_reg) <<< 1);
        if (segment.depth_fraction > DEPTH_W'(1 << DEPTH_FRAC_BITS))
            depth_clamped = DEPTH_W'(1 << DEPTH_FRAC_BITS);
        else
            depth_clamped = segment.depth_fraction;
        dsq_next = DSQ_W'(DSQ_W'(depth_clamped) * DSQ_W'(depth_clamped));

        ctl_next.visible     = segment.extrusion ? show_extrusion_reg : show_travel_reg;
        ctl_next.highlighted = segment.highlighted;
        ctl_next.excluded    = segment.excluded;
        priority if (segment.excluded)
        begin
            ctl_next.stroke_width = 2'd1;
            ctl_next.base_alpha   = OPA_60;
        end
        else if (segment.highlighted)
        begin
            ctl_next.stroke_width = 2'd3;
            ctl_next.base_alpha   = OPA_COVER;
        end
        else if (segment.extrusion)
        begin
            ctl_next.stroke_width = 2'd2;
            ctl_next.base_alpha   = OPA_90;
        end
        else
        begin
            ctl_next.stroke_width = 2'd1;
            ctl_next.base_alpha   = OPA_60;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff_reg <= diff_next;
            dsq_reg  <= dsq_next;
            ctl1_reg <= ctl_next;
        end
    end

    // Stage 2: height times reciprocal range, and the quadratic depth
    // factor. A height at or below the offset gives a zero product.
    logic [PROD_W-1:0]        prod_next, prod_reg;
    logic [DSQ_W-1:0]         depth_rem;
    logic [DSQ_W+7:0]         depth_term;
    logic [7:0]               depth_alpha_next, depth_alpha_reg;
    seg_ctl_t                 ctl2_reg;

    always_comb
    begin
        if (diff_reg[DIFF_W-1] || diff_reg == '0)
            prod_next = '0;
        else
            prod_next = PROD_W'(diff_reg[DIFF_W-2:0]) * PROD_W'(height_scale_reg);
        depth_rem        = DSQ_W'(1 << (2 * DEPTH_FRAC_BITS)) - dsq_reg;
        depth_term       = (DSQ_W+8)'(depth_rem) * (DSQ_W+8)'(OPA_60);
        depth_alpha_next = OPA_40 + depth_term[2*DEPTH_FRAC_BITS +: 8];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg        <= prod_next;
            depth_alpha_reg <= depth_alpha_next;
            ctl2_reg        <= ctl1_reg;
        end
    end

    // Stage 3: Q1.16 fraction, rainbow band and ramp, colour overrides,
    // and base opacity times depth factor.
    logic [PROD_W-FRAC_SHIFT-1:0] frac_raw;
    logic [16:0]                  frac;
    logic [1:0]                   band;
    logic [14:0]                  band_pos;
    logic [14:0]                  band_rest;
    logic [22:0]                  up_prod, down_prod;
    logic [7:0]                   ramp_up, ramp_down;
    logic [7:0]                   red_next, green_next, blue_next;
    logic [7:0]                   red3_reg, green3_reg, blue3_reg;
    logic [15:0]                  opa_prod_next, opa_prod_reg;
    seg_ctl_t                     ctl3_reg;

    always_comb
    begin
        frac_raw = prod_reg[PROD_W-1:FRAC_SHIFT];
        if (frac_raw > (PROD_W-FRAC_SHIFT)'(FRAC_ONE))
            frac = FRAC_ONE;
        else
            frac = frac_raw[16:0];
        // The full-scale fraction lands at the top end of the last band.
        if (frac[16])
        begin
            band     = 2'd3;
            band_pos = 15'd16384;
        end
        else
        begin
            band     = frac[15:14];
            band_pos = {1'b0, frac[13:0]};
        end
        band_rest = 15'd16384 - band_pos;
        up_prod   = {band_pos, 8'd0} - 23'(band_pos);
        down_prod = {band_rest, 8'd0} - 23'(band_rest);
        ramp_up   = up_prod[21:14];
        ramp_down = down_prod[21:14];

        priority if (ctl2_reg.excluded)
        begin
            red_next   = excluded_color_reg[23:16];
            green_next = excluded_color_reg[15:8];
            blue_next  = excluded_color_reg[7:0];
        end
        else if (ctl2_reg.highlighted)
        begin
            red_next   = highlight_color_reg[23:16];
            green_next = highlight_color_reg[15:8];
            blue_next  = highlight_color_reg[7:0];
        end
        else
        begin
            unique case (band)
                2'd0:
                begin
                    red_next   = 8'd0;
                    green_next = ramp_up;
                    blue_next  = 8'd255;
                end
                2'd1:
                begin
                    red_next   = 8'd0;
                    green_next = 8'd255;
                    blue_next  = ramp_down;
                end
                2'd2:
                begin
                    red_next   = ramp_up;
                    green_next = 8'd255;
                    blue_next  = 8'd0;
                end
                default:
                begin
                    red_next   = 8'd255;
                    green_next = ramp_down;
                    blue_next  = 8'd0;
                end
            endcase
        end
        opa_prod_next = 16'(ctl2_reg.base_alpha) * 16'(depth_alpha_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red3_reg     <= red_next;
            green3_reg   <= green_next;
            blue3_reg    <= blue_next;
            opa_prod_reg <= opa_prod_next;
            ctl3_reg     <= ctl2_reg;
        end
    end

    // Stage 4: brightness gain with saturation, and the first divide.
    logic [GAIN_W-1:0] gain_clamped;
    logic [17:0]       red_gain, green_gain, blue_gain;
    logic [7:0]        red4_next, green4_next, blue4_next;
    logic [7:0]        red4_reg, green4_reg, blue4_reg;
    logic [7:0]        opa4_next, opa4_reg;
    seg_ctl_t          ctl4_reg;

    function automatic logic [7:0] sat8(input logic [17:0] p);
        return (p[17:8] > 10'd255) ? 8'd255 : p[15:8];
    endfunction

    always_comb
    begin
        if (brightness_reg < GAIN_MIN)
            gain_clamped = GAIN_MIN;
        else if (brightness_reg > GAIN_MAX)
            gain_clamped = GAIN_MAX;
        else
            gain_clamped = brightness_reg;
        red_gain    = 18'(red3_reg) * 18'(gain_clamped);
        green_gain  = 18'(green3_reg) * 18'(gain_clamped);
        blue_gain   = 18'(blue3_reg) * 18'(gain_clamped);
        red4_next   = sat8(red_gain);
        green4_next = sat8(green_gain);
        blue4_next  = sat8(blue_gain);
        opa4_next   = div255(opa_prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red4_reg   <= red4_next;
            green4_reg <= green4_next;
            blue4_reg  <= blue4_next;
            opa4_reg   <= opa4_next;
            ctl4_reg   <= ctl3_reg;
        end
    end

    // Stage 5: global opacity multiply.
    logic [15:0] gopa_prod_next, gopa_prod_reg;
    logic [7:0]  red5_reg, green5_reg, blue5_reg;
    seg_ctl_t    ctl5_reg;

    assign gopa_prod_next = 16'(opa4_reg) * 16'(global_opacity_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            gopa_prod_reg <= gopa_prod_next;
            red5_reg      <= red4_reg;
            green5_reg    <= green4_reg;
            blue5_reg     <= blue4_reg;
            ctl5_reg      <= ctl4_reg;
        end
    end

    // Stage 6: final divide into the output register.
    logic [7:0] opacity_next, opacity_reg;
    logic [7:0] red6_reg, green6_reg, blue6_reg;
    seg_ctl_t   ctl6_reg;

    assign opacity_next = div255(gopa_prod_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            opacity_reg <= opacity_next;
            red6_reg    <= red5_reg;
            green6_reg  <= green5_reg;
            blue6_reg   <= blue5_reg;
            ctl6_reg    <= ctl5_reg;
        end
    end

    assign style.valid        = v6_reg;
    assign style.visible      = ctl6_reg.visible;
    assign style.stroke_width = ctl6_reg.stroke_width;
    assign style.red          = red6_reg;
    assign style.green        = green6_reg;
    assign style.blue         = blue6_reg;
    assign style.opacity      = opacity_reg;

endmodule

`default_nettype wire
